// ===== design/twss_pkg.sv =====
// -----------------------------------------------------------------------------
// twss_pkg - trigger word stream statistics shared definitions
// Field widths, event type codes, statistic indexes, result kinds and the
// constants used to scale configuration values into clock ticks.
// -----------------------------------------------------------------------------
package twss_pkg;

   localparam int PHASE_BINS = 8;
   localparam int PHASE_BITS = $clog2(PHASE_BINS);

   localparam int CFG_W       = 20;
   localparam int CSR_IDX_W   = 2;
   localparam int WORD_W      = 64;
   localparam int TIME_W      = 48;
   localparam int DETAILS_W   = 12;
   localparam int TYPE_W      = 4;
   localparam int STAT_IDX_W  = 5;
   localparam int COUNT_W     = 32;
   localparam int FINE_W      = 5;
   localparam int REQ_DATA_W  = 72;
   localparam int RSP_DATA_W  = 128;

   // veto ticks = floor(veto_ns * 128 / 100) = (veto_ns * VETO_RECIP) >> VETO_SHIFT
   localparam int          VETO_TICKS_W = 21;
   localparam int          VETO_PROD_W  = 48;
   localparam int          VETO_SHIFT   = 27;
   localparam logic [27:0] VETO_RECIP   = 28'd171798692;

   localparam int          GAP_TICKS_W       = 36;
   localparam logic [15:0] TICKS_PER_MS      = 16'd40000;
   localparam logic [GAP_TICKS_W-1:0] REPORT_GAP_RESET  = 36'd20000000;
   localparam logic [GAP_TICKS_W-1:0] IGNORED_GAP_RESET = 36'd200000000;

   localparam logic [FINE_W-1:0]    FINE_OFFSET = 5'h18;
   localparam logic [DETAILS_W-1:0] DETAILS_MAX = 12'hFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VETO        = 2'd0,
      CSR_REPORT_GAP  = 2'd1,
      CSR_IGNORED_GAP = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_TRIGGER = 2'd0,
      KIND_GAP     = 2'd1,
      KIND_UNKNOWN = 2'd2,
      KIND_STAT    = 2'd3
   } kind_type;

   localparam logic [TYPE_W-1:0] TYPE_TRIG_A = 4'd0;
   localparam logic [TYPE_W-1:0] TYPE_TRIG_B = 4'd1;
   localparam logic [TYPE_W-1:0] TYPE_STOP   = 4'd2;
   localparam logic [TYPE_W-1:0] TYPE_START  = 4'd3;

   localparam logic [STAT_IDX_W-1:0] STAT_TRIGGERS    = 5'd0;
   localparam logic [STAT_IDX_W-1:0] STAT_STARTS      = 5'd1;
   localparam logic [STAT_IDX_W-1:0] STAT_ONTIME      = 5'd2;
   localparam logic [STAT_IDX_W-1:0] STAT_RUN_START   = 5'd3;
   localparam logic [STAT_IDX_W-1:0] STAT_RUN_FINISH  = 5'd4;
   localparam logic [STAT_IDX_W-1:0] STAT_IGNORED     = 5'd5;
   localparam logic [STAT_IDX_W-1:0] STAT_SHUTTER     = 5'd6;
   localparam logic [STAT_IDX_W-1:0] STAT_FIRST_SHUT  = 5'd7;
   localparam logic [STAT_IDX_W-1:0] STAT_PHASE_FIRST = 5'd8;
   localparam logic [STAT_IDX_W-1:0] STAT_PHASE_LAST  = 5'd15;
   localparam logic [STAT_IDX_W-1:0] STAT_DOMINANT    = 5'd16;

endpackage

// ===== design/trigger_word_stream_statistics.sv =====
// -----------------------------------------------------------------------------
// trigger_word_stream_statistics - timing link event word decoder
// Decodes trigger, start and stop words, tracks run statistics and serves
// statistic readouts.
// -----------------------------------------------------------------------------
// Usage:
//   req channel: tuser = func (0 event word, 1 statistic read), tdata holds
//   event_word and stat_index. rsp channel: tuser = kind, tdata holds
//   cycle_number, trigger_number and time_value.
//   csr channel: write-only, always ready; index 0 veto, 1 report gap,
//   2 ignored gap. Write only while the block is idle.
//   A beat is captured in the input register and decoded from there; its
//   result (if any) is registered in the output register, from which it is
//   offered on rsp. Throughput is one beat per cycle while rsp is not stalled,
//   set by the single decode stage between the two registers.
//   Trigger headers, stop words and vetoed triggers give no result, nor does a
//   start word whose gap does not exceed the report gap. If rsp is stalled with
//   a result waiting, the decode stage holds its item whether or not it gives a
//   result, and req_tready drops once the input register is full.
//   Reset clears all statistics and loads the default thresholds (veto 0,
//   report gap 500 ms, ignored gap 5000 ms).
// -----------------------------------------------------------------------------
module trigger_word_stream_statistics (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [twss_pkg::REQ_DATA_W-1:0]      req_tdata,  // event_word, stat_index, pad
   input  logic                                 req_tuser,  // func
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [twss_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // cycle_number, trigger_number,
                                                            // time_value
   output logic [1:0]                           rsp_tuser,  // kind
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [twss_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [twss_pkg::CFG_W-1:0]           csr_data
);

   // configuration, kept in ticks
   logic [twss_pkg::VETO_TICKS_W-1:0] veto_ticks_ff, veto_ticks_in;
   logic [twss_pkg::GAP_TICKS_W-1:0]  report_ticks_ff, report_ticks_in;
   logic [twss_pkg::GAP_TICKS_W-1:0]  ignored_ticks_ff, ignored_ticks_in;
   logic [twss_pkg::VETO_PROD_W-1:0]  veto_prod;
   logic [twss_pkg::GAP_TICKS_W-1:0]  gap_prod;

   // input register
   logic                              in_valid_ff, in_valid_in;
   logic                              in_func_ff, in_func_in;
   logic [twss_pkg::WORD_W-1:0]       in_word_ff, in_word_in;
   logic [twss_pkg::STAT_IDX_W-1:0]   in_idx_ff, in_idx_in;

   // statistics state
   logic                              awaiting_ff, awaiting_in;
   logic [twss_pkg::TIME_W-1:0]       header_time_ff, header_time_in;
   logic [twss_pkg::DETAILS_W-1:0]    prev_details_ff, prev_details_in;
   logic [63:0]                       shutter_ff, shutter_in;
   logic [63:0]                       origin_shutter_ff, origin_shutter_in;
   logic [twss_pkg::TIME_W-1:0]       last_cmd_ff, last_cmd_in;
   logic [63:0]                       last_fine_ff, last_fine_in;
   logic [twss_pkg::COUNT_W-1:0]      trig_total_ff, trig_total_in;
   logic [twss_pkg::COUNT_W-1:0]      start_total_ff, start_total_in;
   logic [63:0]                       ontime_ff, ontime_in;
   logic [twss_pkg::TIME_W-1:0]       run_start_ff, run_start_in;
   logic [twss_pkg::TIME_W-1:0]       run_finish_ff, run_finish_in;
   logic [63:0]                       ignored_ff, ignored_in;
   logic [twss_pkg::COUNT_W-1:0]      phase_ff [twss_pkg::PHASE_BINS];
   logic [twss_pkg::COUNT_W-1:0]      phase_in [twss_pkg::PHASE_BINS];

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [twss_pkg::RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [1:0]                        rsp_kind_ff, rsp_kind_in;

   logic                              advance;

   // decode wires
   logic [twss_pkg::TYPE_W-1:0]       ev_type;
   logic [twss_pkg::DETAILS_W-1:0]    ev_details;
   logic [twss_pkg::TIME_W-1:0]       ev_time;
   logic [twss_pkg::FINE_W-1:0]       fine_sub;
   logic [63:0]                       fine_time;
   logic [63:0]                       veto_diff;
   logic [63:0]                       gap;
   logic [63:0]                       shutter_new;
   logic [63:0]                       origin_new;
   logic [twss_pkg::PHASE_BITS-1:0]   bin;
   logic [twss_pkg::COUNT_W-1:0]      best;
   logic [63:0]                       dominant;
   logic [63:0]                       stat_value;
   logic [twss_pkg::STAT_IDX_W-1:0]   bin_idx;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

   // configuration scaling
   assign veto_prod = twss_pkg::VETO_PROD_W'(csr_data) *
                      twss_pkg::VETO_PROD_W'(twss_pkg::VETO_RECIP);
   assign gap_prod  = twss_pkg::GAP_TICKS_W'(csr_data) *
                      twss_pkg::GAP_TICKS_W'(twss_pkg::TICKS_PER_MS);

   always_comb begin
      veto_ticks_in    = veto_ticks_ff;
      report_ticks_in  = report_ticks_ff;
      ignored_ticks_in = ignored_ticks_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            twss_pkg::CSR_VETO: begin
               veto_ticks_in = veto_prod[twss_pkg::VETO_SHIFT +: twss_pkg::VETO_TICKS_W];
            end
            twss_pkg::CSR_REPORT_GAP: begin
               report_ticks_in = gap_prod;
            end
            twss_pkg::CSR_IGNORED_GAP: begin
               ignored_ticks_in = gap_prod;
            end
            default: begin
            end
         endcase
      end
   end

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_func_in  = in_func_ff;
      in_word_in  = in_word_ff;
      in_idx_in   = in_idx_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_func_in  = req_tuser;
         in_word_in  = req_tdata[twss_pkg::WORD_W-1:0];
         in_idx_in   = req_tdata[twss_pkg::WORD_W +: twss_pkg::STAT_IDX_W];
      end
   end

   // field decode and arithmetic
   assign ev_type    = in_word_ff[63:60];
   assign ev_details = in_word_ff[59:48];
   assign ev_time    = in_word_ff[twss_pkg::TIME_W-1:0];
   assign fine_sub   = in_word_ff[36:32] + twss_pkg::FINE_OFFSET;
   assign fine_time  = {11'd0, header_time_ff, fine_sub};
   assign veto_diff  = fine_time - last_fine_ff;
   assign gap        = {16'd0, ev_time} - {16'd0, last_cmd_ff};
   assign bin        = ev_time[twss_pkg::PHASE_BITS-1:0];
   assign bin_idx    = in_idx_ff - twss_pkg::STAT_PHASE_FIRST;

   always_comb begin
      shutter_new = shutter_ff;
      if (prev_details_ff == twss_pkg::DETAILS_MAX && ev_details == '0) begin
         shutter_new[63:twss_pkg::DETAILS_W] = shutter_ff[63:twss_pkg::DETAILS_W] + 52'd1;
      end
      shutter_new[twss_pkg::DETAILS_W-1:0] = ev_details;
      origin_new = (origin_shutter_ff == '0) ? shutter_new : origin_shutter_ff;
   end

   // lowest bin holding the largest nonzero count
   always_comb begin
      best     = '0;
      dominant = '1;
      for (int i = 0; i < twss_pkg::PHASE_BINS; i++) begin
         if (phase_ff[i] > best) begin
            best     = phase_ff[i];
            dominant = 64'(i);
         end
      end
   end

   always_comb begin
      stat_value = '0;
      case (in_idx_ff)
         twss_pkg::STAT_TRIGGERS:   stat_value = 64'(trig_total_ff);
         twss_pkg::STAT_STARTS:     stat_value = 64'(start_total_ff);
         twss_pkg::STAT_ONTIME:     stat_value = ontime_ff;
         twss_pkg::STAT_RUN_START:  stat_value = 64'(run_start_ff);
         twss_pkg::STAT_RUN_FINISH: stat_value = 64'(run_finish_ff);
         twss_pkg::STAT_IGNORED:    stat_value = ignored_ff;
         twss_pkg::STAT_SHUTTER:    stat_value = shutter_ff;
         twss_pkg::STAT_FIRST_SHUT: stat_value = origin_shutter_ff;
         twss_pkg::STAT_DOMINANT:   stat_value = dominant;
         default: begin
            if (in_idx_ff >= twss_pkg::STAT_PHASE_FIRST &&
                in_idx_ff <= twss_pkg::STAT_PHASE_LAST &&
                32'(bin_idx) < 32'(twss_pkg::PHASE_BINS)) begin
               stat_value = 64'(phase_ff[bin_idx[twss_pkg::PHASE_BITS-1:0]]);
            end
         end
      endcase
   end

   // state update and result
   always_comb begin
      awaiting_in       = awaiting_ff;
      header_time_in    = header_time_ff;
      prev_details_in   = prev_details_ff;
      shutter_in        = shutter_ff;
      origin_shutter_in = origin_shutter_ff;
      last_cmd_in       = last_cmd_ff;
      last_fine_in      = last_fine_ff;
      trig_total_in     = trig_total_ff;
      start_total_in    = start_total_ff;
      ontime_in         = ontime_ff;
      run_start_in      = run_start_ff;
      run_finish_in     = run_finish_ff;
      ignored_in        = ignored_ff;
      phase_in          = phase_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_tready;
      rsp_data_in       = rsp_data_ff;
      rsp_kind_in       = rsp_kind_ff;

      if (advance) begin
         if (in_func_ff) begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = twss_pkg::KIND_STAT;
            rsp_data_in  = {stat_value, 32'd0, 32'd0};
         end else if (awaiting_ff) begin
            awaiting_in = 1'b0;
            if (veto_diff >= 64'(veto_ticks_ff)) begin
               trig_total_in = trig_total_ff + 32'd1;
               last_fine_in  = fine_time;
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = twss_pkg::KIND_TRIGGER;
               rsp_data_in   = {fine_time - {11'd0, last_cmd_ff, 5'd0},
                                in_word_ff[31:0], shutter_ff[31:0]};
            end
         end else begin
            prev_details_in = ev_details;
            case (ev_type)
               twss_pkg::TYPE_TRIG_A, twss_pkg::TYPE_TRIG_B: begin
                  header_time_in = ev_time;
                  awaiting_in    = 1'b1;
               end
               twss_pkg::TYPE_STOP: begin
                  ontime_in     = ontime_ff + gap;
                  run_finish_in = ev_time;
                  last_cmd_in   = ev_time;
               end
               twss_pkg::TYPE_START: begin
                  start_total_in    = start_total_ff + 32'd1;
                  shutter_in        = shutter_new;
                  origin_shutter_in = origin_new;
                  if (origin_shutter_ff == '0) begin
                     run_start_in = ev_time;
                  end
                  if (last_cmd_ff != '0) begin
                     if (gap > 64'(report_ticks_ff)) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = twss_pkg::KIND_GAP;
                        rsp_data_in  = {gap, 32'd0, 32'(shutter_new - origin_new)};
                     end
                     if (gap > 64'(ignored_ticks_ff)) begin
                        ignored_in = ignored_ff + gap;
                     end
                  end
                  phase_in[bin] = phase_ff[bin] + 32'd1;
                  last_cmd_in   = ev_time;
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = twss_pkg::KIND_UNKNOWN;
                  rsp_data_in  = {in_word_ff, 32'd0, 32'd0};
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         veto_ticks_ff     <= '0;
         report_ticks_ff   <= twss_pkg::REPORT_GAP_RESET;
         ignored_ticks_ff  <= twss_pkg::IGNORED_GAP_RESET;
         in_valid_ff       <= 1'b0;
         awaiting_ff       <= 1'b0;
         header_time_ff    <= '0;
         prev_details_ff   <= '0;
         shutter_ff        <= '0;
         origin_shutter_ff <= '0;
         last_cmd_ff       <= '0;
         last_fine_ff      <= '0;
         trig_total_ff     <= '0;
         start_total_ff    <= '0;
         ontime_ff         <= '0;
         run_start_ff      <= '0;
         run_finish_ff     <= '0;
         ignored_ff        <= '0;
         for (int i = 0; i < twss_pkg::PHASE_BINS; i++) begin
            phase_ff[i] <= '0;
         end
         rsp_valid_ff      <= 1'b0;
      end else begin
         veto_ticks_ff     <= veto_ticks_in;
         report_ticks_ff   <= report_ticks_in;
         ignored_ticks_ff  <= ignored_ticks_in;
         in_valid_ff       <= in_valid_in;
         awaiting_ff       <= awaiting_in;
         header_time_ff    <= header_time_in;
         prev_details_ff   <= prev_details_in;
         shutter_ff        <= shutter_in;
         origin_shutter_ff <= origin_shutter_in;
         last_cmd_ff       <= last_cmd_in;
         last_fine_ff      <= last_fine_in;
         trig_total_ff     <= trig_total_in;
         start_total_ff    <= start_total_in;
         ontime_ff         <= ontime_in;
         run_start_ff      <= run_start_in;
         run_finish_ff     <= run_finish_in;
         ignored_ff        <= ignored_in;
         phase_ff          <= phase_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      in_func_ff  <= in_func_in;
      in_word_ff  <= in_word_in;
      in_idx_ff   <= in_idx_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
   end

endmodule
